// ===== rtl/edg_pkg.sv =====
package edg_pkg;

	localparam int ASG_DEPTH = 1024;
	localparam int EXP_DEPTH = 64;
	localparam int AW = $clog2(ASG_DEPTH);
	localparam int CW = AW + 1;
	localparam int EW = $clog2(EXP_DEPTH);
	localparam int OFW = $clog2(EXP_DEPTH + 1);

	localparam int OPW = 3;
	localparam int EIDW = 6;
	localparam int POSW = 10;
	localparam int TOKW = 10;
	localparam int SLOTW = 6;
	localparam int TOTW = 11;
	localparam int STW = 2;
	localparam int CFGW = 7;
	localparam int PICKS_MAX = 64;

	typedef enum logic [OPW-1:0] {
		OP_LOAD     = 3'd0,
		OP_FINALIZE = 3'd1,
		OP_GROUPED  = 3'd2,
		OP_INVERSE  = 3'd3,
		OP_EXPERT   = 3'd4,
		OP_CLEAR    = 3'd5
	} op_t;

	typedef enum logic [STW-1:0] {
		ST_OK         = 2'd0,
		ST_BAD_EXPERT = 2'd1,
		ST_FULL       = 2'd2,
		ST_NOT_READY  = 2'd3
	} status_t;

	typedef struct packed {
		logic [EIDW-1:0]  expert;
		logic [TOKW-1:0]  token;
		logic [SLOTW-1:0] slot;
		logic [POSW-1:0]  rank;
	} asg_t;

	typedef struct packed {
		logic accept;
		logic clear;
		logic ld_commit;
		logic pfx_start;
		logic pfx_rd;
		logic pfx_acc;
		logic scan_start;
		logic scan_rd;
		logic scan_off;
		logic scan_wr;
		logic fin_set;
		logic grd_asg;
		logic inv_off;
		logic res_wr;
	} cmd_t;

	typedef struct packed {
		logic [STW-1:0] in_stat;
		logic           pfx_last;
		logic           scan_last;
		logic           loaded_zero;
		logic [CW-1:0]  loaded;
		logic           fin;
	} sts_t;

endpackage

// ===== rtl/edg_in_if.sv =====
interface edg_in_if;
	logic                       valid;
	logic                       ready;
	logic [edg_pkg::OPW-1:0]    opcode;
	logic [edg_pkg::EIDW-1:0]   expert_id;
	logic [edg_pkg::POSW-1:0]   position;

	modport source (output valid, opcode, expert_id, position, input ready);
	modport sink (input valid, opcode, expert_id, position, output ready);
endinterface

// ===== rtl/edg_out_if.sv =====
interface edg_out_if;
	logic                       valid;
	logic                       ready;
	logic [edg_pkg::EIDW-1:0]   expert_id_out;
	logic [edg_pkg::TOKW-1:0]   source_token;
	logic [edg_pkg::SLOTW-1:0]  slot;
	logic [edg_pkg::POSW-1:0]   other_position;
	logic [edg_pkg::TOTW-1:0]   expert_total;
	logic [edg_pkg::TOTW-1:0]   expert_start;
	logic [edg_pkg::STW-1:0]    status;

	modport source (output valid, expert_id_out, source_token, slot, other_position,
		expert_total, expert_start, status, input ready);
	modport sink (input valid, expert_id_out, source_token, slot, other_position,
		expert_total, expert_start, status, output ready);
endinterface

// ===== rtl/edg_ram.sv =====
module edg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/edg_ctrl.sv =====
module edg_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [edg_pkg::OPW-1:0] in_op,
	output logic                    in_ready,
	input  logic                    out_ready,
	output logic                    out_valid,
	input  edg_pkg::sts_t           sts,
	output edg_pkg::cmd_t           cmd
);
	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_LOAD     = 13'b0000000000010,
		S_PFX_RD   = 13'b0000000000100,
		S_PFX_ACC  = 13'b0000000001000,
		S_SCAN_RD  = 13'b0000000010000,
		S_SCAN_OFF = 13'b0000000100000,
		S_SCAN_WR  = 13'b0000001000000,
		S_FIN      = 13'b0000010000000,
		S_GRD1     = 13'b0000100000000,
		S_GRD2     = 13'b0001000000000,
		S_INV1     = 13'b0010000000000,
		S_INV2     = 13'b0100000000000,
		S_RES      = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   stat_ok;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign stat_ok   = (sts.in_stat == edg_pkg::ST_OK);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (in_op)
						edg_pkg::OP_LOAD:     state_d = stat_ok ? S_LOAD : S_RES;
						edg_pkg::OP_FINALIZE: begin
							cmd.pfx_start = 1'b1;
							state_d = S_PFX_RD;
						end
						edg_pkg::OP_GROUPED:  state_d = stat_ok ? S_GRD1 : S_RES;
						edg_pkg::OP_INVERSE:  state_d = stat_ok ? S_INV1 : S_RES;
						edg_pkg::OP_EXPERT:   state_d = S_RES;
						edg_pkg::OP_CLEAR: begin
							cmd.clear = 1'b1;
							state_d = S_RES;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_LOAD: begin
				if (out_free) begin
					cmd.ld_commit = 1'b1;
					cmd.res_wr = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_PFX_RD: begin
				cmd.pfx_rd = 1'b1;
				state_d = S_PFX_ACC;
			end
			S_PFX_ACC: begin
				cmd.pfx_acc = 1'b1;
				if (!sts.pfx_last) begin
					state_d = S_PFX_RD;
				end else if (sts.loaded_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d = S_SCAN_OFF;
			end
			S_SCAN_OFF: begin
				cmd.scan_off = 1'b1;
				state_d = S_SCAN_WR;
			end
			S_SCAN_WR: begin
				cmd.scan_wr = 1'b1;
				state_d = sts.scan_last ? S_FIN : S_SCAN_RD;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.fin_set = 1'b1;
					cmd.res_wr = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_GRD1: begin
				cmd.grd_asg = 1'b1;
				state_d = S_GRD2;
			end
			S_INV1: begin
				cmd.inv_off = 1'b1;
				state_d = S_INV2;
			end
			S_GRD2, S_INV2, S_RES: begin
				if (out_free) begin
					cmd.res_wr = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_wr) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/edg_datapath.sv =====
module edg_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  edg_pkg::cmd_t              cmd,
	output edg_pkg::sts_t              sts,
	input  logic [edg_pkg::OPW-1:0]    in_opcode,
	input  logic [edg_pkg::EIDW-1:0]   in_expert_id,
	input  logic [edg_pkg::POSW-1:0]   in_position,
	input  logic [edg_pkg::CFGW-1:0]   expert_count,
	input  logic [edg_pkg::CFGW-1:0]   picks_per_token,
	output logic [edg_pkg::EIDW-1:0]   expert_id_out,
	output logic [edg_pkg::TOKW-1:0]   source_token,
	output logic [edg_pkg::SLOTW-1:0]  slot,
	output logic [edg_pkg::POSW-1:0]   other_position,
	output logic [edg_pkg::TOTW-1:0]   expert_total,
	output logic [edg_pkg::TOTW-1:0]   expert_start,
	output logic [edg_pkg::STW-1:0]    status
);
	localparam int CW = edg_pkg::CW;
	localparam int AW = edg_pkg::AW;
	localparam int EW = edg_pkg::EW;
	localparam int OFW = edg_pkg::OFW;
	localparam int CFGW = edg_pkg::CFGW;

	logic [edg_pkg::OPW-1:0]   op_q;
	logic [edg_pkg::EIDW-1:0]  eid_q;
	logic [edg_pkg::STW-1:0]   stat_q;
	logic [CW-1:0]             loaded_q;
	logic [edg_pkg::TOKW-1:0]  tok_q;
	logic [edg_pkg::SLOTW-1:0] slot_q;
	logic                      fin_q;
	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             acc_q;
	logic [edg_pkg::EXP_DEPTH-1:0]   hist_v_q;
	logic [edg_pkg::EXP_DEPTH:0]     off_v_q;
	logic                      hist_rv_q, off_rv_q;

	logic [CFGW-1:0] lim, picks;
	logic            bad_e;
	logic [edg_pkg::STW-1:0] in_stat;

	logic            hist_re, hist_we;
	logic [EW-1:0]   hist_raddr;
	logic [CW-1:0]   hist_rd, hist_val, hist_inc;
	logic            asg_re, asg_we;
	logic [AW-1:0]   asg_raddr;
	logic [31:0]     asg_raw;
	edg_pkg::asg_t   asg_rd, asg_wr;
	logic            grp_re, grp_we;
	logic [AW-1:0]   grp_rd;
	logic            off_re, off_we;
	logic [OFW-1:0]  off_raddr, off_waddr;
	logic [CW-1:0]   off_rd, off_val, acc_n;
	logic [CW:0]     dst;
	logic [edg_pkg::POSW-1:0] rank;

	assign lim   = (expert_count < CFGW'(edg_pkg::EXP_DEPTH)) ? expert_count
		: CFGW'(edg_pkg::EXP_DEPTH);
	assign picks = (picks_per_token == '0) ? CFGW'(1)
		: (picks_per_token > CFGW'(edg_pkg::PICKS_MAX)) ? CFGW'(edg_pkg::PICKS_MAX)
		: picks_per_token;
	assign bad_e = {1'b0, in_expert_id} >= lim;

	always_comb begin
		in_stat = edg_pkg::ST_OK;
		unique case (in_opcode)
			edg_pkg::OP_LOAD: begin
				if (bad_e) in_stat = edg_pkg::ST_BAD_EXPERT;
				else if (loaded_q >= CW'(edg_pkg::ASG_DEPTH)) in_stat = edg_pkg::ST_FULL;
			end
			edg_pkg::OP_GROUPED, edg_pkg::OP_INVERSE: begin
				if (!fin_q || ({1'b0, in_position} >= loaded_q))
					in_stat = edg_pkg::ST_NOT_READY;
			end
			edg_pkg::OP_EXPERT: begin
				if (bad_e) in_stat = edg_pkg::ST_BAD_EXPERT;
				else if (!fin_q) in_stat = edg_pkg::ST_NOT_READY;
			end
			default: in_stat = edg_pkg::ST_OK;
		endcase
	end

	// histogram: bins that were never written read as zero
	assign hist_re    = (cmd.accept && (in_opcode == edg_pkg::OP_LOAD
		|| in_opcode == edg_pkg::OP_EXPERT)) || cmd.pfx_rd;
	assign hist_raddr = cmd.pfx_rd ? idx_q[EW-1:0] : in_expert_id;
	assign hist_val   = hist_rv_q ? hist_rd : '0;
	assign hist_inc   = hist_val + CW'(1);
	assign hist_we    = cmd.ld_commit;
	assign rank       = hist_val[edg_pkg::POSW-1:0];

	assign asg_re    = (cmd.accept && in_opcode == edg_pkg::OP_INVERSE)
		|| cmd.scan_rd || cmd.grd_asg;
	assign asg_raddr = cmd.scan_rd ? idx_q[AW-1:0] : cmd.grd_asg ? grp_rd : in_position;
	assign asg_rd    = edg_pkg::asg_t'(asg_raw);
	assign asg_we    = cmd.ld_commit;
	assign asg_wr    = '{expert: eid_q, token: tok_q, slot: slot_q, rank: rank};

	assign off_re    = (cmd.accept && in_opcode == edg_pkg::OP_EXPERT)
		|| cmd.scan_off || cmd.inv_off;
	assign off_raddr = cmd.accept ? OFW'(in_expert_id) : OFW'(asg_rd.expert);
	assign off_val   = off_rv_q ? off_rd : '0;
	assign off_we    = cmd.pfx_acc;
	assign off_waddr = OFW'(idx_q) + OFW'(1);
	assign acc_n     = acc_q + hist_val;

	assign dst    = {1'b0, off_val} + (CW+1)'(asg_rd.rank);
	assign grp_re = cmd.accept && in_opcode == edg_pkg::OP_GROUPED;
	assign grp_we = cmd.scan_wr && (dst < (CW+1)'(edg_pkg::ASG_DEPTH));

	edg_ram #(.WIDTH(CW), .DEPTH(edg_pkg::EXP_DEPTH)) u_hist (
		.clk(clk), .we(hist_we), .waddr(eid_q), .wdata(hist_inc),
		.re(hist_re), .raddr(hist_raddr), .rdata(hist_rd)
	);
	edg_ram #(.WIDTH(32), .DEPTH(edg_pkg::ASG_DEPTH)) u_asg (
		.clk(clk), .we(asg_we), .waddr(loaded_q[AW-1:0]), .wdata(asg_wr),
		.re(asg_re), .raddr(asg_raddr), .rdata(asg_raw)
	);
	edg_ram #(.WIDTH(AW), .DEPTH(edg_pkg::ASG_DEPTH)) u_grp (
		.clk(clk), .we(grp_we), .waddr(dst[AW-1:0]), .wdata(idx_q[AW-1:0]),
		.re(grp_re), .raddr(in_position), .rdata(grp_rd)
	);
	edg_ram #(.WIDTH(CW), .DEPTH(edg_pkg::EXP_DEPTH + 1)) u_off (
		.clk(clk), .we(off_we), .waddr(off_waddr), .wdata(acc_n),
		.re(off_re), .raddr(off_raddr), .rdata(off_rd)
	);

	assign sts.in_stat     = in_stat;
	assign sts.pfx_last    = (idx_q == CW'(edg_pkg::EXP_DEPTH - 1));
	assign sts.scan_last   = (CW'(idx_q + CW'(1)) == loaded_q);
	assign sts.loaded_zero = (loaded_q == '0);
	assign sts.loaded      = loaded_q;
	assign sts.fin         = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= '0;
			tok_q     <= '0;
			slot_q    <= '0;
			fin_q     <= 1'b0;
			hist_v_q  <= '0;
			off_v_q   <= '0;
			hist_rv_q <= 1'b0;
			off_rv_q  <= 1'b0;
		end else begin
			if (hist_re) hist_rv_q <= hist_v_q[hist_raddr];
			if (off_re) off_rv_q <= off_v_q[off_raddr];
			if (cmd.clear) begin
				loaded_q <= '0;
				tok_q    <= '0;
				slot_q   <= '0;
				fin_q    <= 1'b0;
				hist_v_q <= '0;
				off_v_q  <= '0;
			end else begin
				if (cmd.ld_commit) begin
					loaded_q <= loaded_q + CW'(1);
					fin_q <= 1'b0;
					hist_v_q[eid_q] <= 1'b1;
					// wrap the slot at the pick count, then step the token
					if ((CFGW'(slot_q) + CFGW'(1)) >= picks) begin
						slot_q <= '0;
						tok_q  <= tok_q + edg_pkg::TOKW'(1);
					end else begin
						slot_q <= slot_q + edg_pkg::SLOTW'(1);
					end
				end
				if (cmd.fin_set) fin_q <= 1'b1;
				if (cmd.pfx_acc) off_v_q[off_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= in_opcode;
			eid_q  <= in_expert_id;
			stat_q <= in_stat;
		end
		if (cmd.pfx_start || cmd.scan_start) begin
			idx_q <= '0;
		end else if (cmd.pfx_acc || cmd.scan_wr) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.pfx_start) acc_q <= '0;
		else if (cmd.pfx_acc) acc_q <= acc_n;

		if (cmd.res_wr) begin
			expert_id_out  <= '0;
			source_token   <= '0;
			slot           <= '0;
			other_position <= '0;
			expert_total   <= '0;
			expert_start   <= '0;
			status         <= stat_q;
			if (stat_q == edg_pkg::ST_OK) begin
				unique case (op_q)
					edg_pkg::OP_LOAD: begin
						expert_id_out  <= eid_q;
						source_token   <= tok_q;
						slot           <= slot_q;
						other_position <= loaded_q[AW-1:0];
						expert_total   <= hist_inc;
					end
					edg_pkg::OP_FINALIZE: expert_total <= loaded_q;
					edg_pkg::OP_GROUPED: begin
						expert_id_out  <= asg_rd.expert;
						source_token   <= asg_rd.token;
						slot           <= asg_rd.slot;
						other_position <= grp_rd;
					end
					edg_pkg::OP_INVERSE: begin
						expert_id_out  <= asg_rd.expert;
						source_token   <= asg_rd.token;
						slot           <= asg_rd.slot;
						other_position <= dst[AW-1:0];
					end
					edg_pkg::OP_EXPERT: begin
						expert_id_out <= eid_q;
						expert_total  <= hist_val;
						expert_start  <= off_val;
					end
					default: status <= stat_q;
				endcase
			end
		end
	end
endmodule

// ===== rtl/expert_dispatch_grouping_top.sv =====
// Expert dispatch grouping: counting-sort grouping of token-to-expert picks.
// Channels: req carries one command word (opcode, expert_id, position);
// rsp returns one result word per command; opcodes 6 and 7 give no word.
// Both use valid/ready, a word moves when valid and ready are high together.
// The APB port writes expert_count (address 0) and picks_per_token (address 4);
// write them only while the block is idle.
// Steps per word, from the accept to the result register:
//   load, read expert, clear and any rejected command: accept, then result
//   read grouped, read inverse: two dependent memory reads, then result
//   finalize: accept, a prefix walk that reads and sums every bin of the
//   histogram memory, then for each loaded assignment the scatter (read entry,
//   read offset, write grouped table; skipped if nothing is loaded), then result.
// One command is in work at a time; the controller walks each through the
// single-port reads of its memories.
// Reset empties everything at once through valid bits on the histogram and
// offset memories; no clearing pass. The tables hold garbage until written.
// When the receiver stalls, the result word holds in the output register and
// the next command is still taken; its result waits until the register frees.
module expert_dispatch_grouping_top (
	input  logic        clk,
	input  logic        arst_n,
	edg_in_if.sink      req,
	edg_out_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [edg_pkg::CFGW-1:0] expert_count_q;
	logic [edg_pkg::CFGW-1:0] picks_per_token_q;
	logic                     cfg_wr;
	edg_pkg::cmd_t            cmd;
	edg_pkg::sts_t            sts;

	// register file: expert_count at word 0, picks_per_token at word 1
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = paddr[2] ? {25'd0, picks_per_token_q} : {25'd0, expert_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expert_count_q    <= edg_pkg::CFGW'(64);
			picks_per_token_q <= edg_pkg::CFGW'(2);
		end else if (cfg_wr) begin
			if (paddr[2]) picks_per_token_q <= pwdata[edg_pkg::CFGW-1:0];
			else expert_count_q <= pwdata[edg_pkg::CFGW-1:0];
		end
	end

	// sequencer: takes a word, drives the datapath step by step
	edg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_op(req.opcode), .in_ready(req.ready),
		.out_ready(rsp.ready), .out_valid(rsp.valid),
		.sts(sts), .cmd(cmd)
	);

	// counters, memories and the result register
	edg_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_opcode(req.opcode), .in_expert_id(req.expert_id), .in_position(req.position),
		.expert_count(expert_count_q), .picks_per_token(picks_per_token_q),
		.expert_id_out(rsp.expert_id_out), .source_token(rsp.source_token),
		.slot(rsp.slot), .other_position(rsp.other_position),
		.expert_total(rsp.expert_total), .expert_start(rsp.expert_start),
		.status(rsp.status)
	);

	// a clear drops the fill count and the finalized mark by the next edge
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.opcode == edg_pkg::OP_CLEAR)
		|=> (sts.loaded == '0 && !sts.fin))
		else $error("clear did not empty the tables");

	// each committed load advances the fill count by one
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_commit |=> (sts.loaded == edg_pkg::CW'($past(sts.loaded) + 1'b1)))
		else $error("load did not advance the fill count");

	// a result word appears only after a result write
	a_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.res_wr))
		else $error("result word without a result write");
endmodule
